// File: sv/wsd_pkg.sv
// Shared types and constants for the work-stealing deque.
package wsd_pkg;

   localparam int DEPTH_LOG2_DEF = 10;
   localparam int TASK_WIDTH_DEF = 64;
   localparam int TASK_PORT_W    = 64;
   localparam int CSR_W          = 4;
   localparam logic [CSR_W-1:0] CAP_LOG2_RESET = 4'd10;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_STEAL = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   // Memory strobes from the index logic to the task store
   typedef struct packed {
      logic wr;
      logic rd;
   } mem_ctl_type;

   // Result flags that travel alongside the pending memory read
   typedef struct packed {
      logic ok;
      logic take;
      logic can_steal;
   } meta_type;

endpackage

// File: sv/wsd_if.sv
// Valid/ready channel interfaces for commands and results.
interface wsd_req_if import wsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   cmd_type                cmd;
   logic [TASK_PORT_W-1:0] task_in;

   modport source (output valid, output cmd, output task_in, input ready);
   modport sink (input valid, input cmd, input task_in, output ready);
endinterface

interface wsd_rsp_if import wsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [TASK_PORT_W-1:0] task_out;
   logic                   can_steal;

   modport source (output valid, output ok, output task_out, output can_steal, input ready);
   modport sink (input valid, input ok, input task_out, input can_steal, output ready);
endinterface

// File: sv/work_stealing_deque.sv
// Top level of the serialized bounded work-stealing deque.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    cmd, task_in
//   rsp_chan  out  valid/ready    ok, task_out, can_steal
//   csr_*     in   csr_we         csr_wdata (capacity_log2)
//
// One command is accepted per cycle while req_chan.ready is high; each result
// passes the read-wait stage and the output register. Indices update at the accepting
// edge and the task store is written or read at the same edge, so a pop right after a push sees its task.
// The result stage holds its beat while rsp_chan.ready is low; req_chan.ready
// drops only when both the read-wait stage and the output register are full.
// Reset clears the indices and sets capacity_log2 to 10; the store is not
// cleared, as only pushed slots are ever read.
module work_stealing_deque import wsd_pkg::*; #(
   parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
   parameter int TASK_WIDTH = TASK_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   wsd_req_if.sink          req_chan,
   wsd_rsp_if.source        rsp_chan
);

   logic                  req_acc;
   mem_ctl_type           mem_ctl;
   logic [DEPTH_LOG2-1:0] mem_addr;
   logic [TASK_WIDTH-1:0] mem_wdata;
   logic [TASK_WIDTH-1:0] mem_rdata;
   meta_type              meta;

   assign req_acc = req_chan.valid & req_chan.ready;

   wsd_ctrl #(
      .DEPTH_LOG2 (DEPTH_LOG2),
      .TASK_WIDTH (TASK_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .acc       (req_acc),
      .cmd       (req_chan.cmd),
      .task_in   (req_chan.task_in),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .meta      (meta)
   );

   wsd_store #(
      .DEPTH_LOG2 (DEPTH_LOG2),
      .TASK_WIDTH (TASK_WIDTH)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (mem_addr),
      .wdata   (mem_wdata),
      .rdata   (mem_rdata)
   );

   wsd_resp #(
      .TASK_WIDTH (TASK_WIDTH)
   ) u_resp (
      .clock         (clock),
      .reset         (reset),
      .acc           (req_acc),
      .meta          (meta),
      .rdata         (mem_rdata),
      .req_ready     (req_chan.ready),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ok        (rsp_chan.ok),
      .rsp_task_out  (rsp_chan.task_out),
      .rsp_can_steal (rsp_chan.can_steal)
   );

endmodule

// File: sv/wsd_store.sv
// Task ring buffer: one shared address serves a write port and a registered read port.
module wsd_store import wsd_pkg::*; #(
   parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
   parameter int TASK_WIDTH = TASK_WIDTH_DEF
) (
   input  logic                  clock,
   input  mem_ctl_type           mem_ctl,
   input  logic [DEPTH_LOG2-1:0] addr,
   input  logic [TASK_WIDTH-1:0] wdata,
   output logic [TASK_WIDTH-1:0] rdata
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [TASK_WIDTH-1:0] mem [DEPTH];
   logic [TASK_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         mem[addr] <= wdata;
      end
      if (mem_ctl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/wsd_ctrl.sv
// Top/bottom index registers, capacity register and command decode.
module wsd_ctrl import wsd_pkg::*; #(
   parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
   parameter int TASK_WIDTH = TASK_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   acc,
   input  cmd_type                cmd,
   input  logic [TASK_PORT_W-1:0] task_in,
   output mem_ctl_type            mem_ctl,
   output logic [DEPTH_LOG2-1:0]  mem_addr,
   output logic [TASK_WIDTH-1:0]  mem_wdata,
   output meta_type               meta
);

   localparam int IDX_W = DEPTH_LOG2 + 1;
   localparam int LG_W  = $clog2(DEPTH_LOG2 + 1);

   logic [IDX_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0] bot_ff, bot_in;
   logic [CSR_W-1:0] cap_log2_ff;
   logic [IDX_W-1:0] count;
   logic [IDX_W-1:0] last;
   logic [LG_W-1:0]  cap_lg;
   logic [IDX_W-1:0] cap_n;
   logic             nonempty;
   logic             wr;
   logic             rd;

   assign count    = bot_ff - top_ff;
   assign last     = bot_ff - IDX_W'(1);
   assign nonempty = (count != '0);

   // Clamp the capacity to the built depth, and at least two entries
   always_comb begin
      if (32'(cap_log2_ff) > DEPTH_LOG2) begin
         cap_lg = LG_W'(DEPTH_LOG2);
      end else if (cap_log2_ff == '0) begin
         cap_lg = LG_W'(1);
      end else begin
         cap_lg = LG_W'(cap_log2_ff);
      end
   end

   assign cap_n = IDX_W'(1) << cap_lg;

   always_comb begin
      top_in    = top_ff;
      bot_in    = bot_ff;
      wr        = 1'b0;
      rd        = 1'b0;
      mem_addr  = bot_ff[DEPTH_LOG2-1:0];
      meta.ok   = 1'b0;
      meta.take = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (count < cap_n) begin
               wr      = 1'b1;
               bot_in  = bot_ff + IDX_W'(1);
               meta.ok = 1'b1;
            end
         end
         CMD_POP: begin
            mem_addr = last[DEPTH_LOG2-1:0];
            if (nonempty) begin
               rd        = 1'b1;
               meta.ok   = 1'b1;
               meta.take = 1'b1;
               // taking the last task advances top so both indices meet
               if (count == IDX_W'(1)) begin
                  top_in = top_ff + IDX_W'(1);
               end else begin
                  bot_in = last;
               end
            end
         end
         CMD_STEAL: begin
            mem_addr = top_ff[DEPTH_LOG2-1:0];
            if (nonempty) begin
               rd        = 1'b1;
               meta.ok   = 1'b1;
               meta.take = 1'b1;
               top_in    = top_ff + IDX_W'(1);
            end
         end
         CMD_QUERY: begin
            meta.ok = 1'b1;
         end
         default: begin
            meta.ok = 1'b0;
         end
      endcase
      meta.can_steal = ((bot_in - top_in) != '0);
   end

   assign mem_ctl.wr = wr & acc;
   assign mem_ctl.rd = rd & acc;
   assign mem_wdata  = task_in[TASK_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff      <= '0;
         bot_ff      <= '0;
         cap_log2_ff <= CAP_LOG2_RESET;
      end else begin
         if (acc) begin
            top_ff <= top_in;
            bot_ff <= bot_in;
         end
         if (csr_we) begin
            cap_log2_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: sv/wsd_resp.sv
// Read-wait stage and output register with backpressure.
module wsd_resp import wsd_pkg::*; #(
   parameter int TASK_WIDTH = TASK_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   acc,
   input  meta_type               meta,
   input  logic [TASK_WIDTH-1:0]  rdata,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic [TASK_PORT_W-1:0] rsp_task_out,
   output logic                   rsp_can_steal
);

   logic                   s1_valid_ff, s1_valid_in;
   meta_type               s1_meta_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_ok_ff;
   logic                   out_can_steal_ff;
   logic [TASK_PORT_W-1:0] out_task_ff;
   logic                   adv;

   // advance the read-wait stage whenever the output register frees up
   assign adv       = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | adv;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_meta_ff <= meta;
      end
      if (adv) begin
         out_ok_ff        <= s1_meta_ff.ok;
         out_can_steal_ff <= s1_meta_ff.can_steal;
         out_task_ff      <= s1_meta_ff.take ? TASK_PORT_W'(rdata) : '0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_ok        = out_ok_ff;
   assign rsp_task_out  = out_task_ff;
   assign rsp_can_steal = out_can_steal_ff;

endmodule

// File: sv/wsd_checker.sv
// Port-level checks on the deque's result channel, bound to the top level.
module wsd_checker import wsd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_ok,
   input logic [TASK_PORT_W-1:0] rsp_task_out,
   input logic                   rsp_can_steal
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_task_out) && $stable(rsp_can_steal))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a failed command carries no task
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_task_out == '0)
      else $error("failed command returned a task");

   // a returned task can only come from a successful pop or steal
   a_task_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_task_out != '0) |-> rsp_ok)
      else $error("task returned without success");

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_ok        (rsp_chan.ok),
   .rsp_task_out  (rsp_chan.task_out),
   .rsp_can_steal (rsp_chan.can_steal)
);
